### src/csem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_pkg - shared types and constants of the counting semaphore table
// command and status codes, the stored entry layout and the sequencer states
// ----------------------------------------------------------------------------
package csem_pkg;

	localparam int ID_W    = 16;
	localparam int COUNT_W = 16;
	localparam int WAIT_W  = 8;

	// new event numbers step by two, the top even number is the last one
	localparam int ID_STEP          = 2;
	localparam int ID_LIMIT         = 65534;
	localparam int COUNT_MAX        = 65535;
	localparam int WAITER_FIELD_MAX = 255;

	typedef enum logic [1:0] {
		CMD_OPEN   = 2'd0,
		CMD_WAIT   = 2'd1,
		CMD_SIGNAL = 2'd2,
		CMD_CLOSE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_NONE = 2'd1,
		STAT_FULL = 2'd2,
		STAT_WOVF = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] count;
		logic [WAIT_W-1:0]  waiters;
	} entry_t;

endpackage

`default_nettype wire

### src/counting_semaphore_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table - table of counting semaphores named by even ids
// open creates or looks up an entry, wait takes a unit or blocks, signal
// hands a unit to a waiter or raises the count, close frees the entry
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | cmd, event_id, initial_count
//  out     | out_valid / out_stall| result_id, status, granted, blocked,
//          |                      | released, count_after
//
//  one item at a time: the entry ram is read slot by slot through its single
//  read port, then the last read data returns, the entry is updated and the
//  result loaded, and the sequencer goes back to idle to take the next item
//  reset clears the slot valid flags at once, the ram holds no reset state
//  a stalled result holds the update step until the output register drains;
//  the next item is taken while a finished result still waits
//
module counting_semaphore_table #(
	parameter int NUM_SLOTS   = 16,
	parameter int MAX_WAITERS = 255
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input item
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   cmd,
	input  wire logic [csem_pkg::ID_W-1:0]    event_id,
	input  wire logic [csem_pkg::COUNT_W-1:0] initial_count,
	// result item
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [csem_pkg::ID_W-1:0]         result_id,
	output logic [1:0]                        status,
	output logic                              granted,
	output logic                              blocked,
	output logic [csem_pkg::WAIT_W-1:0]       released,
	output logic [csem_pkg::COUNT_W-1:0]      count_after
);

	import csem_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ENT_W = $bits(entry_t);
	// waiter count field is 8 bits, so the limit never goes past its top
	localparam logic [WAIT_W-1:0] WAIT_LIMIT =
		WAIT_W'((MAX_WAITERS > WAITER_FIELD_MAX) ? WAITER_FIELD_MAX : MAX_WAITERS);

	// sequencer
	state_t state_q, state_d;

	// latched command
	logic [1:0]         cmd_q;
	logic [ID_W-1:0]    ev_q;
	logic [COUNT_W-1:0] init_q;

	// scan address and the read in flight
	logic [IDX_W-1:0] idx_q;
	logic             scan_last;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// what the scan found
	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	entry_t           match_q;
	logic [ID_W-1:0]  max_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// slot valid flags live in flops so reset clears them at once
	logic [NUM_SLOTS-1:0] valid_q;

	// entry ram
	entry_t           rd_ent;
	logic [ENT_W-1:0] ram_rdata;
	logic             ram_we;
	entry_t           wr_ent;
	logic [IDX_W-1:0] wr_idx;

	// update step
	logic               in_acc;
	logic               out_free;
	logic               exec_go;
	logic               ex_we;
	logic               ex_set_v;
	logic               ex_clr_v;
	logic [ID_W:0]      new_id;
	logic [ID_W-1:0]    r_id;
	status_t            r_st;
	logic               r_gr;
	logic               r_bl;
	logic [WAIT_W-1:0]  r_rel;
	logic [COUNT_W-1:0] r_cnt;

	logic               out_valid_q;
	logic [ID_W-1:0]    result_id_q;
	logic [1:0]         status_q;
	logic               granted_q;
	logic               blocked_q;
	logic [WAIT_W-1:0]  released_q;
	logic [COUNT_W-1:0] count_after_q;

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign exec_go   = (state_q == ST_EXEC) && out_free;
	assign scan_last = (idx_q == IDX_W'(NUM_SLOTS - 1));
	assign rd_ent    = entry_t'(ram_rdata);

	csem_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx),
		.wdata (wr_ent),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------------
	// sequencer: idle -> scan every slot -> last read -> update and respond
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// hold here while the previous result is still stalled
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// scan: one ram read per cycle, the compare unit looks at each slot as its
	// data returns: lowest matching slot, largest live id, lowest free slot
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			max_q        <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (in_acc) begin
				idx_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				max_q        <= '0;
			end else begin
				if ((state_q == ST_SCAN) && !scan_last) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_vld_s1) begin
					if (valid_q[idx_s1]) begin
						if (!found_q && (rd_ent.id == ev_q)) begin
							found_q <= 1'b1;
						end
						if (rd_ent.id > max_q) begin
							max_q <= rd_ent.id;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
			end
		end
	end

	// payload side of the scan, no reset needed
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (in_acc) begin
			cmd_q  <= cmd;
			ev_q   <= event_id;
			init_q <= initial_count;
		end
		if (rd_vld_s1) begin
			if (valid_q[idx_s1]) begin
				if (!found_q && (rd_ent.id == ev_q)) begin
					match_idx_q <= idx_s1;
					match_q     <= rd_ent;
				end
			end else if (!free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// update step: decide the command from the scan results
	// ids of live entries are even and never zero, so an odd id or a zero id
	// on wait, signal or close simply finds no match
	// ------------------------------------------------------------------------
	assign new_id = {1'b0, max_q} + (ID_W + 1)'(ID_STEP);

	always_comb begin
		ex_we    = 1'b0;
		ex_set_v = 1'b0;
		ex_clr_v = 1'b0;
		wr_idx   = match_idx_q;
		wr_ent   = match_q;
		r_id     = '0;
		r_st     = STAT_OK;
		r_gr     = 1'b0;
		r_bl     = 1'b0;
		r_rel    = '0;
		r_cnt    = '0;
		if ((cmd_q == CMD_OPEN) && (ev_q == '0)) begin
			// create: needs a free slot and a number that still fits
			if (!free_found_q || (new_id > (ID_W + 1)'(ID_LIMIT))) begin
				r_st = STAT_FULL;
			end else begin
				ex_we          = 1'b1;
				ex_set_v       = 1'b1;
				wr_idx         = free_idx_q;
				wr_ent.id      = new_id[ID_W-1:0];
				wr_ent.count   = init_q;
				wr_ent.waiters = '0;
				r_id           = new_id[ID_W-1:0];
				r_cnt          = init_q;
			end
		end else if (!found_q) begin
			r_st = STAT_NONE;
		end else begin
			case (cmd_q)
				CMD_OPEN: begin
					r_id  = ev_q;
					r_cnt = match_q.count;
				end
				CMD_WAIT: begin
					if (match_q.count != '0) begin
						ex_we        = 1'b1;
						wr_ent.count = match_q.count - 1'b1;
						r_id         = ev_q;
						r_gr         = 1'b1;
						r_cnt        = match_q.count - 1'b1;
					end else if (match_q.waiters >= WAIT_LIMIT) begin
						r_st = STAT_WOVF;
					end else begin
						ex_we          = 1'b1;
						wr_ent.waiters = match_q.waiters + 1'b1;
						r_id           = ev_q;
						r_bl           = 1'b1;
						r_cnt          = match_q.count;
					end
				end
				CMD_SIGNAL: begin
					r_id  = ev_q;
					r_cnt = match_q.count;
					if (match_q.waiters != '0) begin
						// unit goes straight to one waiter
						ex_we          = 1'b1;
						wr_ent.waiters = match_q.waiters - 1'b1;
						r_rel          = WAIT_W'(1);
					end else if (match_q.count != COUNT_W'(COUNT_MAX)) begin
						ex_we        = 1'b1;
						wr_ent.count = match_q.count + 1'b1;
						r_cnt        = match_q.count + 1'b1;
					end
				end
				CMD_CLOSE: begin
					// waiters are rewritten on the next create of this slot
					ex_clr_v = 1'b1;
					r_id     = ev_q;
					r_rel    = match_q.waiters;
					r_cnt    = match_q.count;
				end
				default: begin
					r_st = STAT_NONE;
				end
			endcase
		end
	end

	assign ram_we = ex_we && exec_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (exec_go) begin
			if (ex_set_v) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ex_clr_v) begin
				valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			result_id_q   <= r_id;
			status_q      <= r_st;
			granted_q     <= r_gr;
			blocked_q     <= r_bl;
			released_q    <= r_rel;
			count_after_q <= r_cnt;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_id   = result_id_q;
	assign status      = status_q;
	assign granted     = granted_q;
	assign blocked     = blocked_q;
	assign released    = released_q;
	assign count_after = count_after_q;

endmodule

`default_nettype wire

### src/csem_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csem_ram - generic single write port ram
// one write and one read address per cycle, read data registered
// ----------------------------------------------------------------------------
module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
